@@ design/udp_hfpw_pkg.sv @@
// Package for the UDP header filter: constants, config and record types.
`timescale 1ns / 1ps
`default_nettype none
package udp_hfpw_pkg;

  localparam int unsigned EthHdrBytes  = 14;
  localparam int unsigned IhlUnitBytes = 4;
  localparam int unsigned UdpHdrBytes  = 8;
  localparam int unsigned SrcAddrPos   = 26;
  localparam int unsigned DstAddrPos   = 30;
  localparam int unsigned MinIhl       = 5;
  localparam logic [15:0] PosMax       = 16'hFFFF;

  localparam int unsigned EnSrcAddr = 0;
  localparam int unsigned EnDstAddr = 1;
  localparam int unsigned EnSrcPort = 2;
  localparam int unsigned EnDstPort = 3;
  localparam int unsigned EnOffset  = 4;
  localparam int unsigned EnLength  = 5;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLES  = 3'd0,
    CFG_SRC_ADDR = 3'd1,
    CFG_DST_ADDR = 3'd2,
    CFG_SRC_PORT = 3'd3,
    CFG_DST_PORT = 3'd4,
    CFG_OFFSET   = 3'd5,
    CFG_LENGTH   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic [5:0]  enables;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dport;
    logic [15:0] offset;
    logic [15:0] length;
  } cfg_t;

  typedef struct packed {
    rec_kind_e   kind;
    logic [15:0] size;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dport;
    logic [7:0]  data;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic vld;
    rec_t rec;
  } res_t;

endpackage
`default_nettype wire

@@ design/udp_hfpw_cfg.sv @@
// Configuration register file of the UDP header filter.
`timescale 1ns / 1ps
`default_nettype none
module udp_hfpw_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [udp_hfpw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]                        cfg_data_i,
  output udp_hfpw_pkg::cfg_t                      cfg_o
);

  udp_hfpw_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (udp_hfpw_pkg::cfg_idx_e'(cfg_index_i))
        udp_hfpw_pkg::CFG_ENABLES:  cfg_d.enables  = cfg_data_i[5:0];
        udp_hfpw_pkg::CFG_SRC_ADDR: cfg_d.src_addr = cfg_data_i;
        udp_hfpw_pkg::CFG_DST_ADDR: cfg_d.dst_addr = cfg_data_i;
        udp_hfpw_pkg::CFG_SRC_PORT: cfg_d.src_port = cfg_data_i[15:0];
        udp_hfpw_pkg::CFG_DST_PORT: cfg_d.dport    = cfg_data_i[15:0];
        udp_hfpw_pkg::CFG_OFFSET:   cfg_d.offset   = cfg_data_i[15:0];
        udp_hfpw_pkg::CFG_LENGTH:   cfg_d.length   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ design/udp_hfpw_parse.sv @@
// Input register, frame parse state, filter match and payload window logic.
`timescale 1ns / 1ps
`default_nettype none
module udp_hfpw_parse (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire udp_hfpw_pkg::cfg_t  cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                in_end_i,
  input  wire logic                out_free_i,
  output udp_hfpw_pkg::res_t       res_o
);

  // input register
  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic        fire;

  // frame state
  logic [15:0] pos_q, pos_d;
  logic [5:0]  ihl_bytes_q, ihl_bytes_d;
  logic [31:0] src_q, src_d, dst_q, dst_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d, ulen_q, ulen_d;
  logic        rej_q, rej_d;

  logic        act;
  logic [3:0]  ihl;
  logic [6:0]  udp_start;
  logic        past_start;
  logic [15:0] r, k, size, count, wend;
  logic [16:0] wend_full;
  logic        in_udp, in_pay, hit, pass;

  assign fire       = in_vld_q && out_free_i;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      end_q  <= in_end_i;
    end
  end

  always_comb begin
    act        = pos_q != udp_hfpw_pkg::PosMax;
    ihl        = byte_q[3:0];
    udp_start  = 7'(udp_hfpw_pkg::EthHdrBytes) + {1'b0, ihl_bytes_q};
    past_start = pos_q > 16'(udp_hfpw_pkg::EthHdrBytes) && !rej_q
                 && pos_q >= {9'd0, udp_start};
    r          = pos_q - {9'd0, udp_start};
    in_udp     = past_start && r < 16'(udp_hfpw_pkg::UdpHdrBytes);
    in_pay     = past_start && !in_udp && cfg_i.enables[udp_hfpw_pkg::EnOffset];
    k          = r - 16'(udp_hfpw_pkg::UdpHdrBytes);
    size       = (ulen_q >= 16'(udp_hfpw_pkg::UdpHdrBytes))
                 ? ulen_q - 16'(udp_hfpw_pkg::UdpHdrBytes) : 16'd0;
    count      = cfg_i.enables[udp_hfpw_pkg::EnLength] ? cfg_i.length : size;
    wend_full  = {1'b0, cfg_i.offset} + {1'b0, count};
    wend       = (wend_full > {1'b0, size}) ? size : wend_full[15:0];
    hit        = in_pay && k >= cfg_i.offset && k < wend;
    pass       = !(cfg_i.enables[udp_hfpw_pkg::EnSrcAddr] && src_q != cfg_i.src_addr)
                 && !(cfg_i.enables[udp_hfpw_pkg::EnDstAddr] && dst_q != cfg_i.dst_addr)
                 && !(cfg_i.enables[udp_hfpw_pkg::EnSrcPort] && sport_q != cfg_i.src_port)
                 && !(cfg_i.enables[udp_hfpw_pkg::EnDstPort] && dport_q != cfg_i.dport);

    pos_d       = pos_q;
    ihl_bytes_d = ihl_bytes_q;
    src_d       = src_q;
    dst_d       = dst_q;
    sport_d     = sport_q;
    dport_d     = dport_q;
    ulen_d      = ulen_q;
    rej_d       = rej_q;

    res_o.vld          = 1'b0;
    res_o.rec.kind     = udp_hfpw_pkg::KIND_HEADER;
    res_o.rec.size     = size;
    res_o.rec.src_addr = src_q;
    res_o.rec.dst_addr = dst_q;
    res_o.rec.src_port = sport_q;
    res_o.rec.dport    = dport_q;
    res_o.rec.data     = 8'd0;
    res_o.rec.last     = 1'b0;

    if (fire && act) begin
      if (pos_q == 16'(udp_hfpw_pkg::EthHdrBytes)) begin
        ihl_bytes_d = 6'({2'b00, ihl} * 6'(udp_hfpw_pkg::IhlUnitBytes));
        if (ihl < 4'(udp_hfpw_pkg::MinIhl)) begin
          rej_d = 1'b1;
        end
      end else if (pos_q >= 16'(udp_hfpw_pkg::SrcAddrPos)
                   && pos_q < 16'(udp_hfpw_pkg::DstAddrPos)) begin
        src_d = {src_q[23:0], byte_q};
      end else if (pos_q >= 16'(udp_hfpw_pkg::DstAddrPos)
                   && pos_q < 16'(udp_hfpw_pkg::DstAddrPos + 4)) begin
        dst_d = {dst_q[23:0], byte_q};
      end

      if (in_udp) begin
        if (r < 16'd2) begin
          sport_d = {sport_q[7:0], byte_q};
        end else if (r < 16'd4) begin
          dport_d = {dport_q[7:0], byte_q};
        end else if (r < 16'd6) begin
          ulen_d = {ulen_q[7:0], byte_q};
        end
        if (r == 16'(udp_hfpw_pkg::UdpHdrBytes - 1)) begin
          if (pass) begin
            res_o.vld = 1'b1;
          end else begin
            rej_d = 1'b1;
          end
        end
      end else if (hit) begin
        res_o.vld      = 1'b1;
        res_o.rec.kind = udp_hfpw_pkg::KIND_PAYLOAD;
        res_o.rec.data = byte_q;
        res_o.rec.last = ({1'b0, k} + 17'd1 == {1'b0, wend}) || end_q;
      end
      pos_d = pos_q + 16'd1;
    end

    if (fire && end_q) begin
      pos_d = 16'd0;
      rej_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ihl_bytes_q <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      sport_q     <= '0;
      dport_q     <= '0;
      ulen_q      <= '0;
      rej_q       <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ihl_bytes_q <= ihl_bytes_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      sport_q     <= sport_d;
      dport_q     <= dport_d;
      ulen_q      <= ulen_d;
      rej_q       <= rej_d;
    end
  end

endmodule
`default_nettype wire

@@ design/udp_hfpw_out.sv @@
// Output register driving the record stream.
`timescale 1ns / 1ps
`default_nettype none
module udp_hfpw_out (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire udp_hfpw_pkg::res_t  res_i,
  output logic                     free_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [119:0]             m_axis_tdata,
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast
);

  logic                vld_q;
  udp_hfpw_pkg::rec_t  rec_q;

  assign free_o = !vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= res_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.vld) begin
      rec_q <= res_i.rec;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = rec_q.kind;
  assign m_axis_tlast  = rec_q.last;
  assign m_axis_tdata  = {rec_q.data, rec_q.dport, rec_q.src_port,
                          rec_q.dst_addr, rec_q.src_addr, rec_q.size};

endmodule
`default_nettype wire

@@ design/udp_header_filter_payload_window.sv @@
// Top level of the UDP header filter with payload window.
`timescale 1ns / 1ps
`default_nettype none
// Takes an Ethernet frame one byte per transfer (tlast on the final byte) and
// sustains one byte per cycle while the record side does not stall. Each byte
// passes an input register, the combinational parse/match/window logic and
// an output register, which holds its record until the record side takes it.
// Per frame the block gives one header record (tuser 0) once the UDP header
// is complete and passes the enabled matches, then, with the offset enabled,
// one payload record (tuser 1) per byte in the window, tlast on the final one.
// Backpressure on the record side stalls the byte side through the output
// register. Config writes are taken every cycle and must only be made while
// the block is idle.
module udp_header_filter_payload_window (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [udp_hfpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // frame_byte
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // udp_payload_size, source_address, dest_address, source_port,
  // dest_port, data_byte
  output logic [119:0]                           m_axis_tdata,
  output logic                                   m_axis_tuser,  // record_kind
  output logic                                   m_axis_tlast
);

  udp_hfpw_pkg::cfg_t cfg;
  udp_hfpw_pkg::res_t res;
  logic               out_free;

  udp_hfpw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  udp_hfpw_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .out_free_i (out_free),
    .res_o      (res)
  );

  udp_hfpw_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_hdr_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == udp_hfpw_pkg::KIND_HEADER) |-> !m_axis_tlast)
    else $error("header record carries tlast");

  a_hdr_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == udp_hfpw_pkg::KIND_HEADER)
      |-> m_axis_tdata[119:112] == 8'd0)
    else $error("header record carries a data byte");

  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.vld && out_free) |=> m_axis_tvalid)
    else $error("record lost at output register");

  a_res_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> out_free)
    else $error("record produced while output register full");
`endif

endmodule
`default_nettype wire
